FILE: hw/rtl/spdc_pkg.sv
package spdc_pkg;

	localparam int MAX_TAXA         = 16;
	localparam int MAX_PATTERNS     = 256;
	localparam int CODES_PER_COLUMN = 16;
	localparam int TAXA_LIMIT       = (MAX_TAXA < CODES_PER_COLUMN) ? MAX_TAXA : CODES_PER_COLUMN;
	localparam int TABLE_CAP        = (MAX_PATTERNS < 256) ? MAX_PATTERNS : 256;
	localparam int IDX_W            = 8;
	localparam int STORED_W         = IDX_W + 1;
	localparam int COL_W            = 2 * CODES_PER_COLUMN;
	localparam int CNT_W            = 16;
	localparam int TAXA_W           = 5;
	localparam int MODE_W           = 2;
	localparam int IN_DATA_W        = 40;
	localparam int OUT_DATA_W       = 72;
	localparam int OUT_USER_W       = 2;

	localparam logic [TAXA_W-1:0]   TAXA_RESET = TAXA_W'(16);
	localparam logic [CNT_W-1:0]    COUNT_MAX  = '1;
	localparam logic [STORED_W-1:0] TABLE_CAP_V = STORED_W'(TABLE_CAP);

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_FINISH
	} spdc_state_t;

	typedef struct packed {
		logic accept;
		logic scan_rd;
		logic read_rd;
		logic finish;
	} spdc_cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic out_free;
	} spdc_stat_t;

	function automatic logic [COL_W-1:0] taxa_mask(input logic [TAXA_W-1:0] taxa);
		logic [TAXA_W:0]    n;
		logic [COL_W-1:0]   m;
		n = {1'b0, taxa};
		if (n == '0)
			n = (TAXA_W+1)'(1);
		if (n > (TAXA_W+1)'(TAXA_LIMIT))
			n = (TAXA_W+1)'(TAXA_LIMIT);
		m = '0;
		for (int i = 0; i < CODES_PER_COLUMN; i++) begin
			if ((TAXA_W+1)'(i) < n)
				m[2*i +: 2] = 2'b11;
		end
		return m;
	endfunction

endpackage

FILE: hw/rtl/spdc_ctrl.sv
module spdc_ctrl
	import spdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MODE_W-1:0] in_mode,
	output logic              in_ready,
	input  spdc_stat_t        stat,
	output spdc_cmd_t         cmd
);

	spdc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (mode_t'(in_mode))
						MODE_INSERT: state_d = ST_SCAN;
						MODE_READ:   state_d = ST_READ;
						MODE_CLEAR,
						MODE_NONE:   state_d = ST_FINISH;
						default:     state_d = ST_FINISH;
					endcase
				end
			end
			ST_SCAN: begin
				priority if (stat.hit) begin
					state_d = ST_FINISH;
				end else if (stat.exhausted) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			ST_READ: begin
				cmd.read_rd = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/spdc_datapath.sv
module spdc_datapath
	import spdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TAXA_W-1:0]     cfg_wdata,
	input  logic [MODE_W-1:0]     in_mode,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  spdc_cmd_t             cmd,
	output spdc_stat_t            stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [OUT_USER_W-1:0] out_user
);

	logic [COL_W-1:0] pattern_mem [TABLE_CAP];
	logic [CNT_W-1:0] count_mem [TABLE_CAP];

	logic [TAXA_W-1:0]   taxa_q;
	mode_t               mode_q;
	logic [COL_W-1:0]    key_q;
	logic [COL_W-1:0]    mask_q;
	logic [IDX_W-1:0]    idx_q;
	logic [STORED_W-1:0] k_q;
	logic [IDX_W-1:0]    kp_q;
	logic                rdv_q;
	logic                hit_q;
	logic [STORED_W-1:0] stored_q;
	logic [COL_W-1:0]    pat_rd_q;
	logic [CNT_W-1:0]    cnt_rd_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    slot_q;
	logic                is_new_q;
	logic                full_q;
	logic [COL_W-1:0]    pat_out_q;
	logic [CNT_W-1:0]    cnt_out_q;
	logic [STORED_W-1:0] unique_q;

	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                match;

	logic [IDX_W-1:0]    slot_d;
	logic                is_new_d;
	logic                full_d;
	logic [COL_W-1:0]    pat_d;
	logic [CNT_W-1:0]    cnt_d;
	logic [STORED_W-1:0] unique_d;
	logic                pat_we;
	logic                cnt_we;
	logic [IDX_W-1:0]    wr_addr;

	assign match         = (pat_rd_q & mask_q) == key_q;
	assign stat.hit      = rdv_q && match;
	assign stat.exhausted = k_q == stored_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign rd_en   = cmd.scan_rd || cmd.read_rd;
	assign rd_addr = cmd.read_rd ? idx_q : k_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taxa_q   <= TAXA_RESET;
			mode_q   <= MODE_NONE;
			k_q      <= '0;
			rdv_q    <= 1'b0;
			hit_q    <= 1'b0;
			stored_q <= '0;
		end else begin
			if (cfg_we)
				taxa_q <= cfg_wdata;
			rdv_q <= cmd.scan_rd;
			if (cmd.accept) begin
				mode_q <= mode_t'(in_mode);
				k_q    <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (cmd.scan_rd)
					k_q <= k_q + STORED_W'(1);
				if (stat.hit)
					hit_q <= 1'b1;
			end
			if (cmd.finish)
				stored_q <= unique_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mask_q <= taxa_mask(taxa_q);
			key_q  <= in_data[COL_W-1:0] & taxa_mask(taxa_q);
			idx_q  <= in_data[COL_W +: IDX_W];
		end
		if (cmd.scan_rd)
			kp_q <= k_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pat_rd_q <= pattern_mem[rd_addr];
			cnt_rd_q <= count_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we)
			pattern_mem[wr_addr] <= key_q;
		if (cnt_we)
			count_mem[wr_addr] <= cnt_d;
	end

	always_comb begin
		slot_d   = '0;
		is_new_d = 1'b0;
		full_d   = 1'b0;
		pat_d    = '0;
		cnt_d    = '0;
		unique_d = stored_q;
		pat_we   = 1'b0;
		cnt_we   = 1'b0;
		wr_addr  = kp_q;
		unique case (mode_q)
			MODE_CLEAR: begin
				unique_d = '0;
			end
			MODE_INSERT: begin
				priority if (hit_q) begin
					slot_d = kp_q;
					pat_d  = pat_rd_q;
					cnt_d  = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + CNT_W'(1);
					cnt_we = cmd.finish;
				end else if (stored_q != TABLE_CAP_V) begin
					slot_d   = stored_q[IDX_W-1:0];
					is_new_d = 1'b1;
					pat_d    = key_q;
					cnt_d    = CNT_W'(1);
					unique_d = stored_q + STORED_W'(1);
					wr_addr  = stored_q[IDX_W-1:0];
					pat_we   = cmd.finish;
					cnt_we   = cmd.finish;
				end else begin
					full_d = 1'b1;
				end
			end
			MODE_READ: begin
				slot_d = idx_q;
				if ({1'b0, idx_q} < stored_q) begin
					pat_d = pat_rd_q;
					cnt_d = cnt_rd_q;
				end
			end
			MODE_NONE: begin
				unique_d = stored_q;
			end
			default: unique_d = stored_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			slot_q    <= slot_d;
			is_new_q  <= is_new_d;
			full_q    <= full_d;
			pat_out_q <= pat_d;
			cnt_out_q <= cnt_d;
			unique_q  <= unique_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_DATA_W - IDX_W - COL_W - CNT_W - STORED_W)'(0),
		unique_q, cnt_out_q, pat_out_q, slot_q};
	assign out_user  = {full_q, is_new_q};

endmodule

FILE: hw/rtl/site_pattern_dedup_counter.sv
// One request is in work at a time; the insert scan reads the pattern memory through its
// single read port, one stored pattern per cycle.
// Reset empties the table and sets taxa_in_use to 16; the memories are not cleared.
module site_pattern_dedup_counter
	import spdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TAXA_W-1:0]     cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// column_codes [31:0], entry_index [39:32]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode [1:0]
	input  logic [MODE_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// slot [7:0], pattern_out [39:8], site_count [55:40], unique_count [64:56]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// is_new [0], table_full [1]
	output logic [OUT_USER_W-1:0] m_tuser
);

	spdc_cmd_t  cmd;
	spdc_stat_t stat;

	spdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spdc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_mode   (s_tuser),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule

FILE: hw/rtl/spdc_checker.sv
module spdc_checker
	import spdc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn before it was taken");

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("new pattern and full table flagged together");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[64:56] == TABLE_CAP_V)
		else $error("table full flagged below capacity");

	a_new_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[55:40] == CNT_W'(1) && m_tdata[64:56] != '0)
		else $error("new pattern without a count of one");

	a_unique_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[64:56] <= TABLE_CAP_V)
		else $error("unique count above capacity");

endmodule

bind site_pattern_dedup_counter spdc_checker u_spdc_checker (.*);

FILE: verif/pattern_table_checker.sv
module pattern_table_checker
	import spdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TAXA_W-1:0]     cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [OUT_USER_W-1:0] m_tuser,
	output int                    pending_results,
	output int                    error_count,
	output int                    results_checked,
	output int                    full_drops
);

	typedef struct packed {
		logic [IDX_W-1:0]    slot;
		logic                is_new;
		logic                table_full;
		logic [COL_W-1:0]    pattern;
		logic [CNT_W-1:0]    site_count;
		logic [STORED_W-1:0] unique_count;
	} table_reply_t;

	logic [COL_W-1:0]    pattern_mem [TABLE_CAP];
	logic [CNT_W-1:0]    count_mem [TABLE_CAP];
	logic [STORED_W-1:0] stored;
	logic [TAXA_W-1:0]   taxa;
	table_reply_t        replies_due [$];
	int                  errors = 0;
	int                  checked = 0;
	int                  drops = 0;

	function automatic logic [COL_W-1:0] active_mask(input logic [TAXA_W-1:0] t);
		int n;
		n = int'(t);
		if (n == 0)
			n = 1;
		if (n > TAXA_LIMIT)
			n = TAXA_LIMIT;
		return COL_W'((64'd1 << (2 * n)) - 64'd1);
	endfunction

	function automatic table_reply_t apply_request(input mode_t mode,
			input logic [COL_W-1:0] col, input logic [IDX_W-1:0] idx);
		table_reply_t     r;
		logic [COL_W-1:0] mask;
		logic [COL_W-1:0] key;
		int               hit;
		int               k;
		r = '0;
		case (mode)
			MODE_CLEAR: begin
				stored = '0;
			end
			MODE_INSERT: begin
				mask = active_mask(taxa);
				key = col & mask;
				hit = -1;
				for (k = 0; k < int'(stored); k++) begin
					if (hit < 0 && (pattern_mem[k] & mask) == key)
						hit = k;
				end
				if (hit >= 0) begin
					if (count_mem[hit] != COUNT_MAX)
						count_mem[hit] = count_mem[hit] + 1'b1;
					r.slot = IDX_W'(hit);
					r.pattern = pattern_mem[hit];
					r.site_count = count_mem[hit];
				end else if (stored < TABLE_CAP_V) begin
					pattern_mem[stored] = key;
					count_mem[stored] = CNT_W'(1);
					r.slot = IDX_W'(stored);
					r.is_new = 1'b1;
					r.pattern = key;
					r.site_count = CNT_W'(1);
					stored = stored + 1'b1;
				end else begin
					r.table_full = 1'b1;
				end
			end
			MODE_READ: begin
				r.slot = idx;
				if (STORED_W'(idx) < stored) begin
					r.pattern = pattern_mem[idx];
					r.site_count = count_mem[idx];
				end
			end
			default: begin
			end
		endcase
		r.unique_count = stored;
		return r;
	endfunction

	task automatic report_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		errors++;
		if (errors <= 10)
			$display("pattern table: %s expected 0x%0h, got 0x%0h", field, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		table_reply_t got;
		if (!arst_n) begin
			stored = '0;
			taxa = TAXA_RESET;
			replies_due.delete();
		end else begin
			if (cfg_we)
				taxa = cfg_wdata;
			if (m_tvalid && m_tready) begin
				checked++;
				got.slot = m_tdata[7:0];
				got.pattern = m_tdata[39:8];
				got.site_count = m_tdata[55:40];
				got.unique_count = m_tdata[64:56];
				got.is_new = m_tuser[0];
				got.table_full = m_tuser[1];
				if (replies_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("pattern table: result with no request outstanding, data 0x%0h",
							m_tdata);
				end else begin
					want = replies_due.pop_front();
					if (want.table_full)
						drops++;
					if (got.slot !== want.slot)
						report_field("slot", 64'(want.slot), 64'(got.slot));
					if (got.is_new !== want.is_new)
						report_field("is_new", 64'(want.is_new), 64'(got.is_new));
					if (got.table_full !== want.table_full)
						report_field("table_full", 64'(want.table_full),
							64'(got.table_full));
					if (got.pattern !== want.pattern)
						report_field("pattern_out", 64'(want.pattern), 64'(got.pattern));
					if (got.site_count !== want.site_count)
						report_field("site_count", 64'(want.site_count),
							64'(got.site_count));
					if (got.unique_count !== want.unique_count)
						report_field("unique_count", 64'(want.unique_count),
							64'(got.unique_count));
				end
			end
			if (s_tvalid && s_tready)
				replies_due.insert(replies_due.size(), apply_request(mode_t'(s_tuser),
					s_tdata[31:0], s_tdata[39:32]));
		end
		pending_results <= replies_due.size();
		error_count <= errors;
		results_checked <= checked;
		full_drops <= drops;
	end

endmodule

FILE: verif/site_pattern_dedup_counter_test.sv
module site_pattern_dedup_counter_test;
	import spdc_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [TAXA_W-1:0]     cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	int pending_results;
	int error_count;
	int results_checked;
	int full_drops;

	bit               tx_idle = 1'b1;
	bit               rx_idle = 1'b1;
	int               inserts_sent = 0;
	int               reads_sent = 0;
	int               clears_sent = 0;
	int               unused_sent = 0;
	int               taxa_writes = 0;
	logic [COL_W-1:0] recent_cols [$];
	logic [COL_W-1:0] fill_cols [TABLE_CAP];

	site_pattern_dedup_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	pattern_table_checker table_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.pending_results (pending_results),
		.error_count     (error_count),
		.results_checked (results_checked),
		.full_drops      (full_drops)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= LIMIT_CYCLES) begin
				$display("Timed out after %0d cycles with %0d results outstanding.",
					cycle_count, pending_results);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// The result side stalls at random after each result while rx_idle is set, and twice holds off long enough
	// for the block to back up and stop taking requests.
	initial begin
		int stall;
		int handshakes;
		handshakes = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				handshakes++;
				stall = rx_idle ? $urandom_range(0, 14) : 0;
				if (handshakes == 30 || handshakes == 300)
					stall = LONG_HOLD;
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	task automatic send_request(input mode_t mode, input logic [COL_W-1:0] col,
			input logic [IDX_W-1:0] idx);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {idx, col};
		do @(posedge clk); while (!s_tready);
		case (mode)
			MODE_CLEAR: clears_sent++;
			MODE_INSERT: inserts_sent++;
			MODE_READ: reads_sent++;
			default: unused_sent++;
		endcase
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_taxa(input logic [TAXA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		taxa_writes++;
	endtask

	// Inserts reuse recent columns with the bits above a random taxon flipped, so that
	// matches and near misses both occur under every taxa setting.
	task automatic random_request();
		int               pick;
		logic [COL_W-1:0] col;
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			send_request(MODE_CLEAR, $urandom, IDX_W'($urandom));
		end else if (pick < 6) begin
			send_request(MODE_NONE, $urandom, IDX_W'($urandom));
		end else if (pick < 16) begin
			send_request(MODE_READ, $urandom, IDX_W'($urandom_range(0, 15)));
		end else if (pick < 26) begin
			send_request(MODE_READ, $urandom, IDX_W'($urandom));
		end else begin
			if (recent_cols.size() > 0 && $urandom_range(0, 1) == 1)
				col = recent_cols[$urandom_range(0, recent_cols.size() - 1)]
					^ (COL_W'($urandom) << (2 * $urandom_range(1, 16)));
			else
				col = $urandom;
			recent_cols.insert(recent_cols.size(), col);
			if (recent_cols.size() > 24)
				void'(recent_cols.pop_front());
			send_request(MODE_INSERT, col, IDX_W'($urandom));
		end
	endtask

	initial begin
		logic [TAXA_W-1:0] plan [5];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_READ, '0, '0);
		send_request(MODE_INSERT, '0, '0);
		send_request(MODE_INSERT, '1, '1);
		send_request(MODE_INSERT, '1, '0);
		send_request(MODE_INSERT, 32'h1B1B_1B1B, 8'h5A);
		send_request(MODE_INSERT, 32'h0000_0001, '0);
		send_request(MODE_INSERT, '0, '1);
		send_request(MODE_READ, '1, 8'd0);
		send_request(MODE_READ, '0, 8'd1);
		send_request(MODE_READ, '0, 8'd2);
		send_request(MODE_READ, '0, 8'd3);
		send_request(MODE_READ, '0, 8'd4);
		send_request(MODE_READ, '0, '1);
		send_request(MODE_NONE, '1, '1);
		send_request(MODE_NONE, '0, '0);
		send_request(MODE_CLEAR, '1, '1);
		send_request(MODE_READ, '0, 8'd0);
		send_request(MODE_INSERT, 32'hE4E4_E4E4, '0);
		send_request(MODE_READ, '0, 8'd0);
		send_request(MODE_CLEAR, '0, '0);

		// Fill every slot with distinct columns, then overflow the table.
		settle();
		write_taxa(5'd31);
		send_request(MODE_CLEAR, '0, '0);
		for (int i = 0; i < TABLE_CAP; i++) begin
			fill_cols[i] = {16'($urandom), 8'(i), 8'($urandom)};
			send_request(MODE_INSERT, fill_cols[i], IDX_W'($urandom));
		end
		repeat (6) send_request(MODE_INSERT, $urandom, IDX_W'($urandom));
		send_request(MODE_INSERT, fill_cols[0], '0);
		send_request(MODE_INSERT, fill_cols[TABLE_CAP - 1], '0);
		send_request(MODE_INSERT, fill_cols[TABLE_CAP / 2], '0);
		send_request(MODE_READ, '0, 8'd0);
		send_request(MODE_READ, '0, '1);
		send_request(MODE_READ, '0, 8'd128);

		// A single compared taxon, first against the full table stored under a wider mask.
		settle();
		write_taxa(5'd0);
		repeat (4) send_request(MODE_INSERT, $urandom, '0);
		send_request(MODE_CLEAR, '0, '0);
		for (int code = 0; code < 4; code++)
			send_request(MODE_INSERT, {30'($urandom), 2'(code)}, '0);
		repeat (4) send_request(MODE_INSERT, $urandom, '0);
		for (int i = 0; i < 5; i++)
			send_request(MODE_READ, '0, IDX_W'(i));

		plan = '{5'd2, 5'd15, 5'd16, 5'd8, 5'($urandom_range(0, 31))};
		for (int p = 0; p < 5; p++) begin
			settle();
			write_taxa(plan[p]);
			if (p == 2) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			repeat (PHASE_ITEMS) random_request();
			tx_idle = 1'b1;
			rx_idle = 1'b1;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Sent %0d inserts, %0d reads, %0d clears and %0d unused-mode requests",
			inserts_sent, reads_sent, clears_sent, unused_sent);
		$display("under %0d taxa settings; %0d results checked, %0d drops on a full table.",
			taxa_writes, results_checked, full_drops);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/spdc_pkg.sv
hw/rtl/spdc_ctrl.sv
hw/rtl/spdc_datapath.sv
hw/rtl/site_pattern_dedup_counter.sv
hw/rtl/spdc_checker.sv
verif/pattern_table_checker.sv
verif/site_pattern_dedup_counter_test.sv
